@@ rtl/qtaff_pkg.sv @@
// Shared constants for the quaternion TRS to affine unit.
// Names the quaternion product slots and the matrix shape; no dependencies.

package qtaff_pkg;

	// Shape of the scaled rotation block (column-major).
	localparam int unsigned NUM_ROWS    = 3;
	localparam int unsigned NUM_COLS    = 3;
	localparam int unsigned NUM_ENTRIES = NUM_ROWS * NUM_COLS;

	// Slots of the nine pairwise quaternion products.
	localparam int unsigned NUM_PRODS = 9;
	localparam int unsigned PI_XX = 0;
	localparam int unsigned PI_YY = 1;
	localparam int unsigned PI_ZZ = 2;
	localparam int unsigned PI_XY = 3;
	localparam int unsigned PI_YZ = 4;
	localparam int unsigned PI_ZX = 5;
	localparam int unsigned PI_XW = 6;
	localparam int unsigned PI_YW = 7;
	localparam int unsigned PI_ZW = 8;

endpackage

@@ rtl/quaternion_trs_to_affine_unit.sv @@
// Top level of the quaternion TRS to affine unit: a four-stage multiplier pipeline.
// Depends on qtaff_pkg for the product slots and the matrix shape.

// Usage:
// One item on the input channel (in_valid / in_ready) carries a rotation
// quaternion, a per-axis scale and a translation. One item on the output
// channel (out_valid / out_ready) carries the twelve entries of the top three
// rows of the column-major affine matrix: three scaled rotation columns and
// the translation column.
// An accepted item moves through the stage registers in order; out_valid rises
// once it reaches the output register, and a stall can hold it on the way.
// While the receiver does not stall, the pipeline takes one item per cycle:
// stage one forms the quaternion products, stage two rounds them and builds
// the rotation entries, stage three multiplies by the scale, stage four
// rounds and saturates into the output register.
// Reset clears all valid bits; the pipeline is empty and in_ready is high.
// When the receiver stalls, the result holds in the output register and each
// stage still loads while the stage after it is free, so bubbles close up and
// new items are taken until every stage holds one. Nothing is dropped or
// repeated.

module quaternion_trs_to_affine_unit #(
	parameter int QUAT_WIDTH  = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [QUAT_WIDTH-1:0]  quat_w,
	input  logic signed [QUAT_WIDTH-1:0]  quat_x,
	input  logic signed [QUAT_WIDTH-1:0]  quat_y,
	input  logic signed [QUAT_WIDTH-1:0]  quat_z,
	input  logic signed [COORD_WIDTH-1:0] scale_x,
	input  logic signed [COORD_WIDTH-1:0] scale_y,
	input  logic signed [COORD_WIDTH-1:0] scale_z,
	input  logic signed [COORD_WIDTH-1:0] trans_x,
	input  logic signed [COORD_WIDTH-1:0] trans_y,
	input  logic signed [COORD_WIDTH-1:0] trans_z,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] col0_x,
	output logic signed [COORD_WIDTH-1:0] col0_y,
	output logic signed [COORD_WIDTH-1:0] col0_z,
	output logic signed [COORD_WIDTH-1:0] col1_x,
	output logic signed [COORD_WIDTH-1:0] col1_y,
	output logic signed [COORD_WIDTH-1:0] col1_z,
	output logic signed [COORD_WIDTH-1:0] col2_x,
	output logic signed [COORD_WIDTH-1:0] col2_y,
	output logic signed [COORD_WIDTH-1:0] col2_z,
	output logic signed [COORD_WIDTH-1:0] col3_x,
	output logic signed [COORD_WIDTH-1:0] col3_y,
	output logic signed [COORD_WIDTH-1:0] col3_z
);

	import qtaff_pkg::*;

	localparam int QFRAC = QUAT_WIDTH - 2;
	localparam int RW    = 2 * QUAT_WIDTH;        // raw quaternion product
	localparam int PW    = QUAT_WIDTH + 2;        // rounded quaternion product
	localparam int EW    = QUAT_WIDTH + 4;        // rotation entry
	localparam int MW    = EW + COORD_WIDTH;      // scaled entry, full precision
	localparam int SW    = MW + 1 - QFRAC;        // scaled entry after rounding shift

	localparam logic [RW:0]             HALF_P = (RW+1)'(1) << (QFRAC - 1);
	localparam logic [MW:0]             HALF_M = (MW+1)'(1) << (QFRAC - 1);
	localparam logic signed [EW-1:0]    ONE_E  = EW'(1) << QFRAC;
	localparam logic [COORD_WIDTH-1:0]  CMAX   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0]  CMIN   = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Stage enables: a stage loads when it is empty or the next one moves.
	logic en_s1, en_s2, en_s3, en_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: the nine pairwise quaternion products.
	logic signed [RW-1:0]          prod_s1  [NUM_PRODS];
	logic signed [COORD_WIDTH-1:0] scale_s1 [NUM_COLS];
	logic signed [COORD_WIDTH-1:0] trans_s1 [NUM_ROWS];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1[PI_XX] <= RW'(quat_x) * RW'(quat_x);
			prod_s1[PI_YY] <= RW'(quat_y) * RW'(quat_y);
			prod_s1[PI_ZZ] <= RW'(quat_z) * RW'(quat_z);
			prod_s1[PI_XY] <= RW'(quat_x) * RW'(quat_y);
			prod_s1[PI_YZ] <= RW'(quat_y) * RW'(quat_z);
			prod_s1[PI_ZX] <= RW'(quat_z) * RW'(quat_x);
			prod_s1[PI_XW] <= RW'(quat_x) * RW'(quat_w);
			prod_s1[PI_YW] <= RW'(quat_y) * RW'(quat_w);
			prod_s1[PI_ZW] <= RW'(quat_z) * RW'(quat_w);
			scale_s1[0]    <= scale_x;
			scale_s1[1]    <= scale_y;
			scale_s1[2]    <= scale_z;
			trans_s1[0]    <= trans_x;
			trans_s1[1]    <= trans_y;
			trans_s1[2]    <= trans_z;
		end
	end

	// Stage 2: round the products half up and build the rotation entries.
	// The entries always fit in EW bits, so no saturation is needed here.
	logic [RW:0]          psum [NUM_PRODS];
	logic signed [EW-1:0] pe   [NUM_PRODS];
	logic signed [EW-1:0] entry_c [NUM_ENTRIES];

	always_comb begin
		for (int k = 0; k < NUM_PRODS; k++) begin
			psum[k] = {prod_s1[k][RW-1], prod_s1[k]} + HALF_P;
			pe[k]   = EW'($signed(psum[k][QFRAC +: PW]));
		end
		entry_c[0] = ONE_E - ((pe[PI_YY] + pe[PI_ZZ]) <<< 1);
		entry_c[1] = (pe[PI_XY] + pe[PI_ZW]) <<< 1;
		entry_c[2] = (pe[PI_ZX] - pe[PI_YW]) <<< 1;
		entry_c[3] = (pe[PI_XY] - pe[PI_ZW]) <<< 1;
		entry_c[4] = ONE_E - ((pe[PI_XX] + pe[PI_ZZ]) <<< 1);
		entry_c[5] = (pe[PI_YZ] + pe[PI_XW]) <<< 1;
		entry_c[6] = (pe[PI_ZX] + pe[PI_YW]) <<< 1;
		entry_c[7] = (pe[PI_YZ] - pe[PI_XW]) <<< 1;
		entry_c[8] = ONE_E - ((pe[PI_XX] + pe[PI_YY]) <<< 1);
	end

	logic signed [EW-1:0]          entry_s2 [NUM_ENTRIES];
	logic signed [COORD_WIDTH-1:0] scale_s2 [NUM_COLS];
	logic signed [COORD_WIDTH-1:0] trans_s2 [NUM_ROWS];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			entry_s2 <= entry_c;
			scale_s2 <= scale_s1;
			trans_s2 <= trans_s1;
		end
	end

	// Stage 3: each entry times the scale of its column.
	logic signed [MW-1:0]          mult_s3  [NUM_ENTRIES];
	logic signed [COORD_WIDTH-1:0] trans_s3 [NUM_ROWS];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int k = 0; k < NUM_ENTRIES; k++) begin
				mult_s3[k] <= MW'(entry_s2[k]) * MW'(scale_s2[k / NUM_ROWS]);
			end
			trans_s3 <= trans_s2;
		end
	end

	// Stage 4: round half up and saturate to the coordinate width.
	logic [MW:0]              msum [NUM_ENTRIES];
	logic [SW-1:0]            mshift [NUM_ENTRIES];
	logic [COORD_WIDTH-1:0]   sat_c [NUM_ENTRIES];
	logic [SW-COORD_WIDTH:0]  upper [NUM_ENTRIES];

	always_comb begin
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			msum[k]   = {mult_s3[k][MW-1], mult_s3[k]} + HALF_M;
			mshift[k] = msum[k][MW:QFRAC];
			upper[k]  = mshift[k][SW-1:COORD_WIDTH-1];
			if (upper[k] == '0 || upper[k] == '1) begin
				sat_c[k] = mshift[k][COORD_WIDTH-1:0];
			end else if (mshift[k][SW-1]) begin
				sat_c[k] = CMIN;
			end else begin
				sat_c[k] = CMAX;
			end
		end
	end

	logic signed [COORD_WIDTH-1:0] col_s4   [NUM_ENTRIES];
	logic signed [COORD_WIDTH-1:0] trans_s4 [NUM_ROWS];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int k = 0; k < NUM_ENTRIES; k++) begin
				col_s4[k] <= $signed(sat_c[k]);
			end
			trans_s4 <= trans_s3;
		end
	end

	assign out_valid = valid_s4;
	assign col0_x    = col_s4[0];
	assign col0_y    = col_s4[1];
	assign col0_z    = col_s4[2];
	assign col1_x    = col_s4[3];
	assign col1_y    = col_s4[4];
	assign col1_z    = col_s4[5];
	assign col2_x    = col_s4[6];
	assign col2_y    = col_s4[7];
	assign col2_z    = col_s4[8];
	assign col3_x    = trans_s4[0];
	assign col3_y    = trans_s4[1];
	assign col3_z    = trans_s4[2];

endmodule
